/* hdl/rbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool package
// Sizes, field types and codes shared by the reference-counted buffer pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

   localparam int NUM_BUFFERS = 64;
   localparam int COUNT_BITS  = 8;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);
   localparam int TOP_W       = $clog2(NUM_BUFFERS + 1);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [TOP_W-1:0]      top_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_ADDREF = 2'd1,
      OP_DROP   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_ALLOC = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   localparam count_type COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam count_type COUNT_ONE  = count_type'(1);
   localparam top_type   TOP_FULL   = top_type'(NUM_BUFFERS);

endpackage

/* hdl/refcounted_buffer_pool_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted buffer pool
// LIFO free stack plus one reference count per buffer, both held in
// single-port synchronous memories.
// ----------------------------------------------------------------------------
// Each transaction has two steps: on accept, the count memory is read at the
// requested index and the free stack at its top; in the exec state, once the
// result register can take a result, both memories are modified and written
// back and the result register is loaded. A new transaction is accepted while
// a result waits on rsp_stall; req_stall holds off the next request until the
// current one has written back. Per-entry valid bits give the reset contents
// at once, so no clearing pass follows reset. Allocate pops the most recently
// freed index and sets its count to one; add and drop adjust the count, a drop
// to zero pushes the buffer back; requests on a free buffer or at the count
// limit are flagged and change nothing.
module refcounted_buffer_pool_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rbp_pkg::op_type        req_op,
   input  rbp_pkg::idx_type       req_buffer_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rbp_pkg::status_type    rsp_status,
   output rbp_pkg::idx_type       rsp_granted_index,
   output logic                   rsp_freed,
   output rbp_pkg::top_type       rsp_free_count,
   output rbp_pkg::count_type     rsp_ref_count
);
   import rbp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type  state_ff, state_in;

   count_type  cnt_mem_ff [NUM_BUFFERS];
   idx_type    stk_mem_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [NUM_BUFFERS-1:0] stk_vld_ff, stk_vld_in;
   top_type    top_ff, top_in;

   op_type     op_ff;
   idx_type    idx_ff;
   idx_type    slot_ff;
   count_type  cnt_rd_ff;
   logic       cnt_rd_vld_ff;
   idx_type    stk_rd_ff;
   logic       stk_rd_vld_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   idx_type    rsp_granted_ff, rsp_granted_in;
   logic       rsp_freed_ff, rsp_freed_in;
   count_type  rsp_count_ff, rsp_count_in;
   top_type    free_cnt_ff;

   logic       accept;
   logic       finish;
   idx_type    rd_slot;
   count_type  cur_count;
   idx_type    got;
   logic       cnt_we;
   idx_type    cnt_waddr;
   count_type  cnt_wdata;
   logic       stk_we;
   idx_type    stk_waddr;
   count_type  new_count;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign rd_slot   = idx_type'(top_ff - top_type'(1));

   assign cur_count = cnt_rd_vld_ff ? cnt_rd_ff : '0;
   assign got       = stk_rd_vld_ff ? stk_rd_ff : slot_ff;

   always_comb begin
      state_in       = state_ff;
      top_in         = top_ff;
      cnt_vld_in     = cnt_vld_ff;
      stk_vld_in     = stk_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_freed_in   = rsp_freed_ff;
      rsp_count_in   = rsp_count_ff;
      cnt_we         = 1'b0;
      cnt_waddr      = idx_ff;
      cnt_wdata      = cur_count;
      stk_we         = 1'b0;
      stk_waddr      = idx_type'(top_ff);
      new_count      = cur_count;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_OK;
               rsp_granted_in = idx_ff;
               rsp_freed_in   = 1'b0;
               rsp_count_in   = cur_count;
               case (op_ff)
                  OP_ALLOC: begin
                     rsp_count_in = '0;
                     if (top_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        top_in         = top_ff - top_type'(1);
                        cnt_we         = 1'b1;
                        cnt_waddr      = got;
                        cnt_wdata      = COUNT_ONE;
                        rsp_granted_in = got;
                        rsp_count_in   = COUNT_ONE;
                     end
                  end
                  OP_ADDREF: begin
                     if (cur_count == '0) begin
                        rsp_status_in = STAT_NOT_ALLOC;
                     end else if (cur_count == COUNT_MAX) begin
                        rsp_status_in = STAT_OVERFLOW;
                     end else begin
                        new_count    = cur_count + COUNT_ONE;
                        cnt_we       = 1'b1;
                        cnt_wdata    = new_count;
                        rsp_count_in = new_count;
                     end
                  end
                  OP_DROP: begin
                     if (cur_count == '0) begin
                        rsp_status_in = STAT_NOT_ALLOC;
                     end else begin
                        new_count    = cur_count - COUNT_ONE;
                        cnt_we       = 1'b1;
                        cnt_wdata    = new_count;
                        rsp_count_in = new_count;
                        if ((new_count == '0) && (top_ff < TOP_FULL)) begin
                           stk_we       = 1'b1;
                           top_in       = top_ff + top_type'(1);
                           rsp_freed_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (cnt_we) begin
                  cnt_vld_in[cnt_waddr] = 1'b1;
               end
               if (stk_we) begin
                  stk_vld_in[stk_waddr] = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= TOP_FULL;
         cnt_vld_ff   <= '0;
         stk_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         cnt_vld_ff   <= cnt_vld_in;
         stk_vld_ff   <= stk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         idx_ff        <= req_buffer_index;
         slot_ff       <= rd_slot;
         cnt_rd_ff     <= cnt_mem_ff[req_buffer_index];
         cnt_rd_vld_ff <= cnt_vld_ff[req_buffer_index];
         stk_rd_ff     <= stk_mem_ff[rd_slot];
         stk_rd_vld_ff <= stk_vld_ff[rd_slot];
      end
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      if (stk_we) begin
         stk_mem_ff[stk_waddr] <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_freed         = rsp_freed_ff;
   assign rsp_ref_count     = rsp_count_ff;

   // Free count after the transaction equals the stack top at result load.
   always_ff @(posedge clock) begin
      if (finish) begin
         free_cnt_ff <= top_in;
      end
   end
   assign rsp_free_count = free_cnt_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool testbench
// Drives allocate, add-reference and drop-reference transactions into the
// reference-counted buffer pool and checks every response against a
// behavioral model of the free stack and per-buffer counts. Directed tests
// cover basic use, exhausting the pool and saturating a count; random
// traffic then runs under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import rbp_pkg::*;

   typedef struct packed {
      status_type status;
      idx_type    granted;
      logic       freed;
      top_type    free_count;
      count_type  ref_count;
   } pool_rsp_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   op_type     req_op           = OP_ALLOC;
   idx_type    req_buffer_index = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   status_type rsp_status;
   idx_type    rsp_granted_index;
   logic       rsp_freed;
   top_type    rsp_free_count;
   count_type  rsp_ref_count;

   idx_type      pool_stack [NUM_BUFFERS];
   top_type      pool_top;
   count_type    pool_counts [NUM_BUFFERS];
   pool_rsp_type expected_rsp [$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   refcounted_buffer_pool_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_buffer_index  (req_buffer_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_freed         (rsp_freed),
      .rsp_free_count    (rsp_free_count),
      .rsp_ref_count     (rsp_ref_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // advance the pool model by one accepted transaction
   function automatic pool_rsp_type pool_apply(op_type op, idx_type idx);
      pool_rsp_type r;
      count_type    cnt;
      idx_type      got;
      r.status  = STAT_OK;
      r.granted = idx;
      r.freed   = 1'b0;
      cnt       = pool_counts[idx];
      case (op)
         OP_ALLOC: begin
            cnt = '0;
            if (pool_top == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               pool_top         = pool_top - top_type'(1);
               got              = pool_stack[idx_type'(pool_top)];
               pool_counts[got] = COUNT_ONE;
               r.granted        = got;
               cnt              = COUNT_ONE;
            end
         end
         OP_ADDREF: begin
            if (cnt == '0) begin
               r.status = STAT_NOT_ALLOC;
            end else if (cnt == COUNT_MAX) begin
               r.status = STAT_OVERFLOW;
            end else begin
               cnt              = cnt + COUNT_ONE;
               pool_counts[idx] = cnt;
            end
         end
         OP_DROP: begin
            if (cnt == '0) begin
               r.status = STAT_NOT_ALLOC;
            end else begin
               cnt              = cnt - COUNT_ONE;
               pool_counts[idx] = cnt;
               if (cnt == '0 && pool_top < TOP_FULL) begin
                  pool_stack[idx_type'(pool_top)] = idx;
                  pool_top                        = pool_top + top_type'(1);
                  r.freed                         = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.free_count = pool_top;
      r.ref_count  = cnt;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("tb: mismatch at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_rsp = {expected_rsp, pool_apply(req_op, req_buffer_index)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_status, want.status));
               if (rsp_granted_index !== want.granted)
                  report_mismatch($sformatf("granted_index %0d, want %0d",
                                            rsp_granted_index, want.granted));
               if (rsp_freed !== want.freed)
                  report_mismatch($sformatf("freed %0b, want %0b",
                                            rsp_freed, want.freed));
               if (rsp_free_count !== want.free_count)
                  report_mismatch($sformatf("free_count %0d, want %0d",
                                            rsp_free_count, want.free_count));
               if (rsp_ref_count !== want.ref_count)
                  report_mismatch($sformatf("ref_count %0d, want %0d",
                                            rsp_ref_count, want.ref_count));
            end
         end
      end
   end

   task automatic send_req(input op_type op, input idx_type idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_op           <= op_type'($urandom_range(3));
         req_buffer_index <= idx_type'($urandom_range(NUM_BUFFERS - 1));
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_buffer_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic idx_type pick_live_index();
      idx_type live [$];
      for (int i = 0; i < NUM_BUFFERS; i++)
         if (pool_counts[i] != '0) live = {live, idx_type'(i)};
      if (live.size() == 0) return idx_type'($urandom_range(NUM_BUFFERS - 1));
      return live[$urandom_range(live.size() - 1)];
   endfunction

   task automatic test_basic_ops();
      send_req(OP_ADDREF, idx_type'(0));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_ALLOC, idx_type'(5));
      send_req(OP_ADDREF, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_NONE, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_NONE, idx_type'(0));
      send_req(OP_ALLOC, idx_type'(0));
      send_req(OP_ALLOC, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 2));
      send_req(OP_DROP, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_ADDREF, idx_type'(NUM_BUFFERS - 2));
   endtask

   task automatic test_pool_exhaust();
      idx_type order [NUM_BUFFERS];
      idx_type tmp;
      int      j;
      for (int i = 0; i < NUM_BUFFERS; i++) send_req(OP_ALLOC, idx_type'(i));
      send_req(OP_ALLOC, idx_type'(0));
      send_req(OP_ALLOC, idx_type'(NUM_BUFFERS - 1));
      send_req(OP_NONE, idx_type'(17));
      send_req(OP_ADDREF, idx_type'(0));
      send_req(OP_DROP, idx_type'(0));
      for (int i = 0; i < NUM_BUFFERS; i++) order[i] = idx_type'(i);
      for (int i = NUM_BUFFERS - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < NUM_BUFFERS; i++) send_req(OP_DROP, order[i]);
      send_req(OP_ALLOC, idx_type'(0));
      send_req(OP_ALLOC, idx_type'(0));
   endtask

   task automatic test_count_saturation();
      idx_type target;
      wait_drained();
      target = pool_stack[idx_type'(pool_top - top_type'(1))];
      send_req(OP_ALLOC, idx_type'($urandom_range(NUM_BUFFERS - 1)));
      repeat (int'(COUNT_MAX) - 1) send_req(OP_ADDREF, target);
      send_req(OP_ADDREF, target);
      send_req(OP_ADDREF, target);
      send_req(OP_NONE, target);
      repeat (int'(COUNT_MAX)) send_req(OP_DROP, target);
      send_req(OP_DROP, target);
      send_req(OP_ADDREF, target);
   endtask

   task automatic test_random_traffic(input int n_items, input int alloc_wt);
      int roll;
      for (int n = 0; n < n_items; n++) begin
         roll = $urandom_range(99);
         if (roll < alloc_wt)
            send_req(OP_ALLOC, idx_type'($urandom_range(NUM_BUFFERS - 1)));
         else if (roll < alloc_wt + 20)
            send_req(OP_ADDREF, pick_live_index());
         else if (roll < 85)
            send_req(OP_DROP, pick_live_index());
         else if (roll < 93)
            send_req(op_type'($urandom_range(1, 2)),
                     idx_type'($urandom_range(NUM_BUFFERS - 1)));
         else
            send_req(op_type'($urandom_range(3)),
                     idx_type'($urandom_range(NUM_BUFFERS - 1)));
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         pool_stack[i]  = idx_type'(i);
         pool_counts[i] = '0;
      end
      pool_top = TOP_FULL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_pool_exhaust();
      test_count_saturation();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(270, 40);
      send_idle_pct = 67;
      rsp_stall_pct = 0;
      test_random_traffic(270, 25);
      send_idle_pct = 0;
      rsp_stall_pct = 67;
      test_random_traffic(270, 20);
      send_idle_pct = 7;
      rsp_stall_pct = 7;
      test_random_traffic(270, 32);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
